// ----- src/urv_pkg.sv -----
// ----------------------------------------------------------------------------
// urv_pkg
// Shared types and constants for the ultrasonic range validator: payload
// words, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package urv_pkg;

  typedef struct packed {
    logic [15:0] flight_time_us;
    logic [7:0]  temp_raw;
    logic [47:0] sample_time_us;
  } req_word_t;

  typedef struct packed {
    logic [23:0]        distance_um;
    logic               in_window;
    logic               sample_valid;
    logic signed [15:0] temp_used_q8;
  } rsp_word_t;

  typedef enum logic [2:0] {
    CFG_MIN_DISTANCE = 3'd0,
    CFG_MAX_DISTANCE = 3'd1,
    CFG_MIN_TEMP     = 3'd2,
    CFG_MAX_TEMP     = 3'd3,
    CFG_FALLBACK     = 3'd4,
    CFG_MAX_GAP      = 3'd5,
    CFG_MAX_STEP     = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    MUL_TEMP  = 2'd0,
    MUL_SPEED = 2'd1,
    MUL_DIST  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     load_prod;
    mul_sel_t mul_sel;
    logic     load_temp;
    logic     load_speed;
    logic     load_dist;
    logic     finish;
  } urv_cmd_t;

  typedef struct packed {
    logic out_free;
  } urv_sts_t;

  // register reset values
  localparam logic [23:0]        MIN_DISTANCE_RST = 24'd50000;
  localparam logic [23:0]        MAX_DISTANCE_RST = 24'd9000000;
  localparam logic signed [15:0] MIN_TEMP_RST     = -16'sd10240;
  localparam logic signed [15:0] MAX_TEMP_RST     = 16'sd21760;
  localparam logic signed [15:0] FALLBACK_RST     = 16'sd5120;
  localparam logic [23:0]        MAX_GAP_RST      = 24'd300000;
  localparam logic [23:0]        MAX_STEP_RST     = 24'd600000;

  // temperature conversion: t = trunc((raw - 64) * 512 / 3) - 4871
  localparam logic signed [8:0]  RAW_OFFSET  = 9'sd64;
  // 512/3 done as |r| * 43691 >> 8, exact for |r| < 256
  localparam logic signed [17:0] RECIP3_X512 = 18'sd43691;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd4871;

  // speed of sound: 84736 + floor(tu * 154 / 256), Q8 m/s
  localparam logic signed [17:0] SPEED_COEF = 18'sd154;
  localparam logic signed [18:0] SPEED_BASE = 19'sd84736;
  localparam logic [16:0]        SPEED_MIN  = 17'd65024;

endpackage

// ----- src/ultrasonic_range_validator.sv -----
// Flow: an accepted request word steps through the temperature, speed and
// distance products, then waits in the check step while the previous result
// word is still stalled in the output register; no new word is taken until
// its result is loaded there. Three products share one multiplier.
// Reset: synchronous; config returns to defaults, stored sample to zero.
// ----------------------------------------------------------------------------
// ultrasonic_range_validator
// Temperature-compensated time-of-flight distance with window, gap and
// step validation against the last in-window sample.
// ----------------------------------------------------------------------------
module ultrasonic_range_validator import urv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_word_t   rsp_word
);

  urv_cmd_t cmd;
  urv_sts_t sts;

  urv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  urv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- src/urv_ctrl.sv -----
// ----------------------------------------------------------------------------
// urv_ctrl
// Sequencer: walks one word through the shared multiplier steps and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module urv_ctrl import urv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  urv_sts_t sts,
  output urv_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_T,
    S_TEMP,
    S_MUL_S,
    S_SPEED,
    S_MUL_D,
    S_DIST,
    S_CHECK
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_TEMP;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL_T;
        end
      end
      S_MUL_T: begin
        cmd.load_prod = 1'b1;
        cmd.mul_sel   = MUL_TEMP;
        state_next    = S_TEMP;
      end
      S_TEMP: begin
        cmd.load_temp = 1'b1;
        state_next    = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.load_prod = 1'b1;
        cmd.mul_sel   = MUL_SPEED;
        state_next    = S_SPEED;
      end
      S_SPEED: begin
        cmd.load_speed = 1'b1;
        state_next     = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.load_prod = 1'b1;
        cmd.mul_sel   = MUL_DIST;
        state_next    = S_DIST;
      end
      S_DIST: begin
        cmd.load_dist = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_wait_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !sts.out_free) |=> state == S_CHECK)
    else $error("sequencer left check step while output was blocked");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.load_prod, cmd.load_temp, cmd.load_speed,
              cmd.load_dist, cmd.finish}))
    else $error("more than one datapath command in a cycle");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> ##6 (state == S_CHECK))
    else $error("word did not reach check step in time");

endmodule

// ----- src/urv_datapath.sv -----
// ----------------------------------------------------------------------------
// urv_datapath
// Config registers, stored last sample, shared 18x18 multiplier and the
// temperature, speed, distance and validity logic, plus output register.
// ----------------------------------------------------------------------------
module urv_datapath import urv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  req_word_t   req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_word_t   rsp_word,
  input  urv_cmd_t    cmd,
  output urv_sts_t    sts
);

  // configuration
  logic [23:0]        range_lo;
  logic [23:0]        range_hi;
  logic signed [15:0] min_temp;
  logic signed [15:0] max_temp;
  logic signed [15:0] fallback_temp;
  logic [23:0]        max_gap;
  logic [23:0]        max_step;

  // stored in-window sample
  logic [23:0] last_distance;
  logic [47:0] last_time;

  // working registers
  req_word_t          cur;
  logic signed [35:0] prod;
  logic signed [15:0] temp_used;
  logic [16:0]        speed;
  logic [23:0]        dist_um;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo      <= MIN_DISTANCE_RST;
      range_hi      <= MAX_DISTANCE_RST;
      min_temp      <= MIN_TEMP_RST;
      max_temp      <= MAX_TEMP_RST;
      fallback_temp <= FALLBACK_RST;
      max_gap       <= MAX_GAP_RST;
      max_step      <= MAX_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_DISTANCE: range_lo      <= cfg_data;
        CFG_MAX_DISTANCE: range_hi      <= cfg_data;
        CFG_MIN_TEMP:     min_temp      <= cfg_data[15:0];
        CFG_MAX_TEMP:     max_temp      <= cfg_data[15:0];
        CFG_FALLBACK:     fallback_temp <= cfg_data[15:0];
        CFG_MAX_GAP:      max_gap       <= cfg_data;
        CFG_MAX_STEP:     max_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  // raw byte offset and magnitude
  logic signed [8:0] raw_off;
  logic [7:0]        raw_mag;
  assign raw_off = $signed({1'b0, cur.temp_raw}) - RAW_OFFSET;
  assign raw_mag = raw_off[8] ? 8'(-raw_off) : raw_off[7:0];

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_p;

  always_comb begin
    case (cmd.mul_sel)
      MUL_TEMP: begin
        mul_a = $signed({10'd0, raw_mag});
        mul_b = RECIP3_X512;
      end
      MUL_SPEED: begin
        mul_a = 18'(temp_used);
        mul_b = SPEED_COEF;
      end
      MUL_DIST: begin
        mul_a = $signed({2'd0, cur.flight_time_us});
        mul_b = $signed({1'b0, speed});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 36'(mul_a) * 36'(mul_b);

  // temperature: truncating divide, then limit check
  logic [15:0]        quot;
  logic signed [16:0] quot_s;
  logic signed [16:0] temp_conv;
  logic               temp_bad;
  assign quot      = prod[23:8];
  assign quot_s    = raw_off[8] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign temp_conv = quot_s - TEMP_OFFSET;
  assign temp_bad  = (temp_conv > 17'(max_temp)) || (temp_conv < 17'(min_temp));

  // speed: arithmetic shift is the floor divide by 256
  logic signed [18:0] speed_sum;
  assign speed_sum = SPEED_BASE + $signed(prod[26:8]);

  // distance, saturated to 24 bits (product is never negative here)
  logic [23:0] dist_sat;
  assign dist_sat = (|prod[35:33]) ? '1 : prod[32:9];

  // window, gap and step checks
  logic        in_win;
  logic [47:0] gap;
  logic [23:0] step;
  logic        valid_n;
  assign in_win  = (dist_um > range_lo) && (dist_um < range_hi);
  assign gap     = cur.sample_time_us - last_time;
  assign step    = (dist_um >= last_distance) ? dist_um - last_distance
                                              : last_distance - dist_um;
  assign valid_n = in_win && (gap < {24'd0, max_gap}) && (step < max_step);

  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= req_word;
    end
    if (cmd.load_prod) begin
      prod <= mul_p;
    end
    if (cmd.load_temp) begin
      temp_used <= temp_bad ? fallback_temp : temp_conv[15:0];
    end
    if (cmd.load_speed) begin
      speed <= speed_sum[16:0];
    end
    if (cmd.load_dist) begin
      dist_um <= dist_sat;
    end
    if (cmd.finish) begin
      rsp_word.distance_um  <= dist_um;
      rsp_word.in_window    <= in_win;
      rsp_word.sample_valid <= valid_n;
      rsp_word.temp_used_q8 <= temp_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid     <= 1'b0;
      last_distance <= '0;
      last_time     <= '0;
    end else begin
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.finish && in_win) begin
        last_distance <= dist_um;
        last_time     <= cur.sample_time_us;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp_valid && rsp_stall))
    else $error("result word overwritten while stalled");

  a_valid_in_window: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp_word.sample_valid || rsp_word.in_window))
    else $error("valid sample outside distance window");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_speed) |-> speed >= SPEED_MIN)
    else $error("speed of sound below possible range");

endmodule

// ----- verif/urv_checker.sv -----
// ----------------------------------------------------------------------------
// urv_checker
// Watches the register port and both word channels of the range validator.
// It keeps its own copy of the registers and of the last in-window sample,
// predicts the result word for every accepted request word, and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module urv_checker import urv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_word_t   req_word,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_word_t   rsp_word,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned checked,
  output int unsigned window_hits,
  output int unsigned valid_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_ZERO    = 64;
  localparam int TEMP_SCALE  = 512;
  localparam int TEMP_DIV    = 3;
  localparam int TEMP_SHIFT  = 4871;
  localparam int SOUND_BASE  = 84736;
  localparam int SOUND_SLOPE = 154;
  localparam logic [63:0] DIST_MAX = 64'hFF_FFFF;

  // register copy
  logic [23:0] win_lo, win_hi, gap_limit, step_limit;
  int          temp_lo, temp_hi, temp_fallback;

  // last in-window sample
  logic [23:0] prev_dist;
  logic [47:0] prev_time;

  rsp_word_t   pending_ranges[$];
  int unsigned n_bad, n_checked, n_window, n_valid;

  function automatic rsp_word_t predict_range(req_word_t w);
    rsp_word_t   r;
    int          temp_q8, used_q8, sound_q8;
    logic [63:0] prod;
    logic [23:0] dist_um, step;
    logic [47:0] gap;
    logic        inwin, ok;
    // C-style division: truncates toward zero for negative readings
    temp_q8  = ((int'(w.temp_raw) - RAW_ZERO) * TEMP_SCALE) / TEMP_DIV - TEMP_SHIFT;
    used_q8  = (temp_q8 > temp_hi || temp_q8 < temp_lo) ? temp_fallback : temp_q8;
    sound_q8 = SOUND_BASE + ((used_q8 * SOUND_SLOPE) >>> 8);
    prod     = (64'(w.flight_time_us) * 64'(sound_q8)) >> 9;
    dist_um  = (prod > DIST_MAX) ? 24'hFF_FFFF : prod[23:0];
    inwin    = (dist_um > win_lo) && (dist_um < win_hi);
    ok       = 1'b0;
    if (inwin) begin
      gap  = w.sample_time_us - prev_time;
      step = (dist_um >= prev_dist) ? dist_um - prev_dist : prev_dist - dist_um;
      ok   = (gap < {24'd0, gap_limit}) && (step < step_limit);
      prev_dist = dist_um;
      prev_time = w.sample_time_us;
    end
    r.distance_um  = dist_um;
    r.in_window    = inwin;
    r.sample_valid = ok;
    r.temp_used_q8 = 16'(used_q8);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      win_lo        = MIN_DISTANCE_RST;
      win_hi        = MAX_DISTANCE_RST;
      temp_lo       = int'(MIN_TEMP_RST);
      temp_hi       = int'(MAX_TEMP_RST);
      temp_fallback = int'(FALLBACK_RST);
      gap_limit     = MAX_GAP_RST;
      step_limit    = MAX_STEP_RST;
      prev_dist     = '0;
      prev_time     = '0;
      pending_ranges.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_DISTANCE: win_lo        = cfg_data;
          CFG_MAX_DISTANCE: win_hi        = cfg_data;
          CFG_MIN_TEMP:     temp_lo       = int'($signed(cfg_data[15:0]));
          CFG_MAX_TEMP:     temp_hi       = int'($signed(cfg_data[15:0]));
          CFG_FALLBACK:     temp_fallback = int'($signed(cfg_data[15:0]));
          CFG_MAX_GAP:      gap_limit     = cfg_data;
          CFG_MAX_STEP:     step_limit    = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        pending_ranges.push_back(predict_range(req_word));
      if (rsp_valid && !rsp_stall) begin
        if (pending_ranges.size() == 0) begin
          $error("result word with no request pending: %p", rsp_word);
          n_bad++;
        end else begin
          want = pending_ranges.pop_front();
          n_checked++;
          if (rsp_word.in_window === 1'b1) n_window++;
          if (rsp_word.sample_valid === 1'b1) n_valid++;
          if (rsp_word.distance_um !== want.distance_um) begin
            $error("distance_um: expected %0d, got %0d", want.distance_um,
                   rsp_word.distance_um);
            n_bad++;
          end
          if (rsp_word.in_window !== want.in_window) begin
            $error("in_window: expected %0d, got %0d", want.in_window, rsp_word.in_window);
            n_bad++;
          end
          if (rsp_word.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, got %0d", want.sample_valid,
                   rsp_word.sample_valid);
            n_bad++;
          end
          if (rsp_word.temp_used_q8 !== want.temp_used_q8) begin
            $error("temp_used_q8: expected %0d, got %0d", want.temp_used_q8,
                   rsp_word.temp_used_q8);
            n_bad++;
          end
        end
      end
    end
    // published by nonblocking assignment on purpose: readers see a stable value
    mismatches  <= n_bad;
    outstanding <= pending_ranges.size();
    checked     <= n_checked;
    window_hits <= n_window;
    valid_hits  <= n_valid;
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Range validator test: a directed pass over window, gap, step and
// temperature-limit corners, then random sensor tracks with noise under
// several register settings, with random idling on both channels and a long
// output hold that backs the block up. Checking lives in urv_checker.
// ----------------------------------------------------------------------------
module tb;
  import urv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED  = 3'd7;   // no register behind it
  localparam int SINK_RANDOM         = 0;
  localparam int SINK_FREE           = 1;
  localparam int SINK_HOLD           = 2;
  localparam int HOLD_CYCLES         = 200;
  localparam int PHASES              = 5;
  localparam int WORDS_PER_PHASE     = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  req_word_t   req_word;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_word_t   rsp_word;

  int unsigned mismatches, outstanding, checked, window_hits, valid_hits;
  int          sink_mode;
  int unsigned settings_used;

  logic [6:0][23:0] cur_regs;
  logic [15:0]      walk_tof;
  logic [47:0]      walk_time;

  ultrasonic_range_validator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  urv_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_word    (req_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_word    (rsp_word),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .window_hits (window_hits),
    .valid_hits  (valid_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_temp();
    int t;
    t = int'($urandom_range(0, 49151)) - 16384;
    return 24'(t);
  endfunction

  function automatic logic [23:0] sext_temp(logic signed [15:0] t);
    return {{8{t[15]}}, t};
  endfunction

  task automatic send_word(input req_word_t w, input int unsigned gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic load_regs(input logic [6:0][23:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 24'($urandom);
    @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_regs = v;
    settings_used++;
  endtask

  task automatic random_regs(output logic [6:0][23:0] v);
    v[CFG_MIN_DISTANCE] = 24'($urandom_range(0, 400000));
    v[CFG_MAX_DISTANCE] = 24'($urandom_range(500000, 16777215));
    v[CFG_MIN_TEMP]     = rand_temp();
    v[CFG_MAX_TEMP]     = rand_temp();
    v[CFG_FALLBACK]     = rand_temp();
    v[CFG_MAX_GAP]      = 24'($urandom_range(0, 2000000));
    v[CFG_MAX_STEP]     = 24'($urandom_range(0, 2000000));
  endtask

  // a tracked target most of the time, plus noise and broken timing
  task automatic next_reading(output req_word_t w);
    int unsigned pick, span, gap_span;
    int          tof;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      gap_span  = cur_regs[CFG_MAX_GAP] + cur_regs[CFG_MAX_GAP] / 8 + 1;
      walk_time = walk_time + 48'($urandom_range(0, gap_span));
      span      = cur_regs[CFG_MAX_STEP] / 128 + 2;
      if (span > 30000) span = 30000;
      tof = int'(walk_tof) + int'($urandom_range(0, 2 * span)) - int'(span);
      if (tof < 1) tof = 1;
      if (tof > 65535) tof = 65535;
      walk_tof = 16'(tof);
      w.flight_time_us = walk_tof;
      w.temp_raw       = 8'($urandom_range(24, 200));
      w.sample_time_us = walk_time;
    end else if (pick < 92) begin
      w.flight_time_us = 16'($urandom);
      w.temp_raw       = 8'($urandom);
      w.sample_time_us = {16'($urandom), 32'($urandom)};
    end else begin
      // timestamp repeats or runs backwards, range jumps
      walk_time = walk_time - 48'($urandom_range(0, 5000));
      walk_tof  = 16'($urandom);
      w.flight_time_us = walk_tof;
      w.temp_raw       = 8'($urandom);
      w.sample_time_us = walk_time;
    end
  endtask

  // output side
  initial begin : sink
    rsp_stall <= 1'b0;
    @(posedge clk);
    forever begin
      case (sink_mode)
        SINK_FREE: begin
          rsp_stall <= 1'b0;
          @(posedge clk);
        end
        SINK_HOLD: begin
          rsp_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          rsp_stall <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        default: begin
          rsp_stall <= ($urandom_range(0, 2) == 0);
          repeat (1 + pick_gap()) @(posedge clk);
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [6:0][23:0] regs;
    req_word_t        w;
    bit               steady;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MIN_DISTANCE;
    cfg_data      <= '0;
    req_valid     <= 1'b0;
    req_word      <= '0;
    sink_mode     <= SINK_RANDOM;
    settings_used = 1;
    cur_regs[CFG_MIN_DISTANCE] = MIN_DISTANCE_RST;
    cur_regs[CFG_MAX_DISTANCE] = MAX_DISTANCE_RST;
    cur_regs[CFG_MIN_TEMP]     = sext_temp(MIN_TEMP_RST);
    cur_regs[CFG_MAX_TEMP]     = sext_temp(MAX_TEMP_RST);
    cur_regs[CFG_FALLBACK]     = sext_temp(FALLBACK_RST);
    cur_regs[CFG_MAX_GAP]      = MAX_GAP_RST;
    cur_regs[CFG_MAX_STEP]     = MAX_STEP_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings; first sample is judged against distance 0 at time 0
    send_word(req_word_t'{16'd1000,  8'd100, 48'd1000}, pick_gap());
    send_word(req_word_t'{16'd0,     8'd0,   48'd2000}, pick_gap());
    send_word(req_word_t'{16'hFFFF,  8'hFF,  48'hFFFF_FFFF_FFFF}, pick_gap());
    send_word(req_word_t'{16'd1000,  8'd64,  48'd5000}, pick_gap());
    send_word(req_word_t'{16'd1010,  8'd64,  48'd4000}, pick_gap());    // time went back
    send_word(req_word_t'{16'd1010,  8'd64,  48'd303999}, pick_gap());  // gap one under
    send_word(req_word_t'{16'd1010,  8'd64,  48'd603999}, pick_gap());  // gap at limit
    send_word(req_word_t'{16'd1010,  8'd63,  48'd700000}, pick_gap());
    drain();

    // temperature limits inverted, fallback 0: distance is tof * 165.5 exactly
    regs[CFG_MIN_DISTANCE] = 24'd165500;
    regs[CFG_MAX_DISTANCE] = 24'd331000;
    regs[CFG_MIN_TEMP]     = 24'd1;
    regs[CFG_MAX_TEMP]     = 24'd0;
    regs[CFG_FALLBACK]     = 24'd0;
    regs[CFG_MAX_GAP]      = 24'hFF_FFFF;
    regs[CFG_MAX_STEP]     = 24'd99300;
    load_regs(regs);
    send_word(req_word_t'{16'd1000, 8'h00, 48'd10}, pick_gap());   // on lower bound
    send_word(req_word_t'{16'd2000, 8'hFF, 48'd20}, pick_gap());   // on upper bound
    send_word(req_word_t'{16'd1200, 8'h80, 48'd30}, pick_gap());
    send_word(req_word_t'{16'd1800, 8'h4D, 48'd40}, pick_gap());   // step at limit
    send_word(req_word_t'{16'd1202, 8'h3F, 48'd50}, pick_gap());
    send_word(req_word_t'{16'd1600, 8'h99, 48'h8000_0000_0000}, pick_gap());
    drain();

    // reading exactly on both temperature limits, zero gap allowance
    regs[CFG_MIN_DISTANCE] = 24'd0;
    regs[CFG_MAX_DISTANCE] = 24'hFF_FFFF;
    regs[CFG_MIN_TEMP]     = sext_temp(-16'sd4871);
    regs[CFG_MAX_TEMP]     = sext_temp(-16'sd4871);
    regs[CFG_FALLBACK]     = sext_temp(-16'sd16384);
    regs[CFG_MAX_GAP]      = 24'd0;
    regs[CFG_MAX_STEP]     = 24'hFF_FFFF;
    load_regs(regs);
    send_word(req_word_t'{16'd3000,  8'd64, 48'd100}, pick_gap());
    send_word(req_word_t'{16'd3000,  8'd63, 48'd100}, pick_gap());
    send_word(req_word_t'{16'd3000,  8'd65, 48'd101}, pick_gap());
    send_word(req_word_t'{16'd0,     8'd64, 48'd102}, pick_gap());
    send_word(req_word_t'{16'hFFFF,  8'd64, 48'd103}, pick_gap());
    drain();

    // distance window inverted, all temperatures believable
    regs[CFG_MIN_DISTANCE] = 24'hFF_FFFF;
    regs[CFG_MAX_DISTANCE] = 24'd0;
    regs[CFG_MIN_TEMP]     = sext_temp(-16'sd16384);
    regs[CFG_MAX_TEMP]     = sext_temp(16'sd32767);
    regs[CFG_FALLBACK]     = sext_temp(16'sd32767);
    regs[CFG_MAX_GAP]      = 24'hFF_FFFF;
    regs[CFG_MAX_STEP]     = 24'd0;
    load_regs(regs);
    send_word(req_word_t'{16'd2000, 8'd120, 48'd200}, pick_gap());
    send_word(req_word_t'{16'd9000, 8'd0,   48'd300}, pick_gap());
    send_word(req_word_t'{16'd500,  8'd255, 48'd400}, pick_gap());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      steady = 1'b0;
      case (p)
        0: begin
          regs[CFG_MIN_DISTANCE] = MIN_DISTANCE_RST;
          regs[CFG_MAX_DISTANCE] = MAX_DISTANCE_RST;
          regs[CFG_MIN_TEMP]     = sext_temp(MIN_TEMP_RST);
          regs[CFG_MAX_TEMP]     = sext_temp(MAX_TEMP_RST);
          regs[CFG_FALLBACK]     = sext_temp(FALLBACK_RST);
          regs[CFG_MAX_GAP]      = MAX_GAP_RST;
          regs[CFG_MAX_STEP]     = MAX_STEP_RST;
          sink_mode <= SINK_RANDOM;
        end
        1: begin
          random_regs(regs);
          sink_mode <= SINK_HOLD;
          steady = 1'b1;
        end
        2: begin
          regs[CFG_MIN_DISTANCE] = 24'd0;
          regs[CFG_MAX_DISTANCE] = 24'hFF_FFFF;
          regs[CFG_MIN_TEMP]     = sext_temp(-16'sd16384);
          regs[CFG_MAX_TEMP]     = sext_temp(16'sd32767);
          regs[CFG_FALLBACK]     = sext_temp(-16'sd16384);
          regs[CFG_MAX_GAP]      = 24'hFF_FFFF;
          regs[CFG_MAX_STEP]     = 24'hFF_FFFF;
          sink_mode <= SINK_FREE;
          steady = 1'b1;
        end
        default: begin
          random_regs(regs);
          sink_mode <= SINK_RANDOM;
        end
      endcase
      load_regs(regs);
      walk_tof  = 16'($urandom_range(400, 50000));
      walk_time = ($urandom_range(0, 3) == 0) ? 48'hFFFF_FF80_0000
                                              : {16'($urandom), 32'($urandom)};
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // the long hold only needs to fill the block a few times
        if (p == 1 && i == 40) begin
          sink_mode <= SINK_RANDOM;
          steady = 1'b0;
        end
        next_reading(w);
        send_word(w, steady ? 0 : pick_gap());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("checked %0d range words under %0d register settings", checked,
             settings_used);
    $display("%0d fell inside the window, %0d passed the gap and step checks",
             window_hits, valid_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ultrasonic_range_validator] OK");
    end else begin
      $display("[ultrasonic_range_validator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("[ultrasonic_range_validator] ERROR");
    $finish;
  end

endmodule
